[rtl/core/fpa_pkg.sv]
`timescale 1ns / 1ps

package fpa_pkg;

  localparam int OFF_W  = 31;
  localparam int LEN_W  = 16;
  localparam int THR_W  = 8;
  localparam int MODE_W = 2;
  localparam int HC_W   = 7;
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  // command codes
  localparam logic CMD_RELEASE = 1'b0;
  localparam logic CMD_ALLOC   = 1'b1;

  // fit policy codes, the unused code behaves as first-fit
  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_FIT_MODE  = 2'd0;
  localparam logic [1:0] REG_SPLIT_THR = 2'd1;
  localparam logic [1:0] REG_INIT_END  = 2'd2;

  localparam logic [MODE_W-1:0] FIT_MODE_RST  = 2'd0;
  localparam logic [THR_W-1:0]  SPLIT_THR_RST = 8'd10;
  localparam logic [OFF_W-1:0]  INIT_END_RST  = 31'd4;

  typedef struct packed {
    logic             cmd;
    logic [OFF_W-1:0] offset;
    logic [LEN_W-1:0] length;
  } in_item_t;

  typedef struct packed {
    logic [OFF_W-1:0] place;
    logic             reused;
    logic             split_done;
    logic             status;
    logic [HC_W-1:0]  hole_count;
  } out_item_t;

endpackage

[rtl/core/fit_policy_free_block_allocator_core.sv]
`timescale 1ns / 1ps

// Free-hole allocator: keeps an ordered list of up to FREE_SLOTS holes (offset, length) in a
// single-port-write, single-read memory and serves one transaction at a time through one
// sequencer that walks the list an entry per cycle. A release enters its hole by the fit policy
// (head, ascending or descending length); an allocate takes the first hole that is large enough,
// unlinks it and re-enters a remainder above split_threshold; with no such hole it appends at
// the end pointer. The list scan and the one-entry-per-cycle shift through the memory set the
// time a transaction takes. in_ready is high only while the sequencer is idle; a finished
// result waits in the output register while the next transaction is taken.
module fit_policy_free_block_allocator_core #(
  parameter int FREE_SLOTS = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  fpa_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output fpa_pkg::out_item_t        out_data,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [fpa_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [fpa_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [fpa_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                      cfg_pready
);

  import fpa_pkg::*;

  localparam int AW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
  localparam int CW = $clog2(FREE_SLOTS + 1);
  localparam logic [CW-1:0] SLOTS = CW'(FREE_SLOTS);

  typedef struct packed {
    logic [OFF_W-1:0] off;
    logic [LEN_W-1:0] len;
  } hole_t;

  typedef enum logic [2:0] {
    S_IDLE, S_ALLOC, S_INSERT, S_SCAN, S_DEL, S_SHIFT, S_DONE
  } state_t;

  // hole list memory
  hole_t          mem [FREE_SLOTS];
  hole_t          rd_q;
  logic [AW-1:0]  rd_addr;
  logic [AW-1:0]  wr_addr;
  hole_t          wr_data;
  logic           we;

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  state_t             state_r, state_nxt;
  logic [CW-1:0]      total_r, total_nxt;
  logic [CW-1:0]      pos_r, pos_nxt;
  logic [CW-1:0]      sh_r, sh_nxt;
  logic [OFF_W-1:0]   end_r, end_nxt;
  logic               cmd_r, cmd_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [OFF_W-1:0]   ins_off_r, ins_off_nxt;
  logic [LEN_W-1:0]   ins_len_r, ins_len_nxt;
  logic [OFF_W-1:0]   hoff_r, hoff_nxt;
  logic [LEN_W-1:0]   rem_r, rem_nxt;
  logic               scan_alloc_r, scan_alloc_nxt;
  logic [OFF_W-1:0]   place_r, place_nxt;
  logic               reused_r, reused_nxt;
  logic               split_r, split_nxt;
  logic               status_r, status_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_q_r, out_q_nxt;
  logic [MODE_W-1:0]  fit_mode_r, fit_mode_nxt;
  logic [THR_W-1:0]   thr_r, thr_nxt;
  logic [OFF_W-1:0]   init_end_r, init_end_nxt;

  logic               cfg_wr;
  logic               scan_hit;
  logic               ordered;
  logic [CW-1:0]      pos_inc;
  logic [CW-1:0]      total_dec;
  logic [CW-1:0]      sh_p1;
  logic [CW-1:0]      sh_p2;
  logic [CW-1:0]      sh_m2;

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_data   = out_q_r;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  assign ordered   = (fit_mode_r == MODE_BEST) || (fit_mode_r == MODE_WORST);
  assign pos_inc   = pos_r + CW'(1);
  assign total_dec = total_r - CW'(1);
  assign sh_p1     = sh_r + CW'(1);
  assign sh_p2     = sh_r + CW'(2);
  assign sh_m2     = sh_r - CW'(2);

  // stop condition of the list walk for the current purpose
  always_comb begin
    if (scan_alloc_r) begin
      scan_hit = (rd_q.len >= len_r);
    end else if (fit_mode_r == MODE_BEST) begin
      scan_hit = (rd_q.len > ins_len_r);
    end else begin
      scan_hit = (rd_q.len <= ins_len_r);
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_paddr[3:2])
      REG_FIT_MODE:  cfg_prdata = CFG_DW'(fit_mode_r);
      REG_SPLIT_THR: cfg_prdata = CFG_DW'(thr_r);
      REG_INIT_END:  cfg_prdata = CFG_DW'(init_end_r);
      default:       cfg_prdata = '0;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    total_nxt      = total_r;
    pos_nxt        = pos_r;
    sh_nxt         = sh_r;
    end_nxt        = end_r;
    cmd_nxt        = cmd_r;
    len_nxt        = len_r;
    ins_off_nxt    = ins_off_r;
    ins_len_nxt    = ins_len_r;
    hoff_nxt       = hoff_r;
    rem_nxt        = rem_r;
    scan_alloc_nxt = scan_alloc_r;
    place_nxt      = place_r;
    reused_nxt     = reused_r;
    split_nxt      = split_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_q_nxt      = out_q_r;
    fit_mode_nxt   = fit_mode_r;
    thr_nxt        = thr_r;
    init_end_nxt   = init_end_r;
    we             = 1'b0;
    wr_addr        = sh_r[AW-1:0];
    wr_data        = rd_q;
    rd_addr        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt     = in_data.cmd;
          len_nxt     = in_data.length;
          ins_off_nxt = in_data.offset;
          ins_len_nxt = in_data.length;
          place_nxt   = in_data.offset;
          reused_nxt  = 1'b0;
          split_nxt   = 1'b0;
          status_nxt  = 1'b0;
          state_nxt   = (in_data.cmd == CMD_ALLOC) ? S_ALLOC : S_INSERT;
        end
      end
      S_ALLOC: begin
        scan_alloc_nxt = 1'b1;
        pos_nxt        = '0;
        if (total_r == '0) begin
          place_nxt = end_r;
          end_nxt   = end_r + OFF_W'(len_r);
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_INSERT: begin
        scan_alloc_nxt = 1'b0;
        pos_nxt        = '0;
        if (total_r == SLOTS) begin
          if (cmd_r == CMD_RELEASE) status_nxt = 1'b1;
          state_nxt = S_DONE;
        end else if (ordered && (total_r != '0)) begin
          state_nxt = S_SCAN;
        end else begin
          // head insert: open the gap at slot 0
          sh_nxt    = total_r;
          rd_addr   = total_dec[AW-1:0];
          state_nxt = S_SHIFT;
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          if (scan_alloc_r) begin
            hoff_nxt   = rd_q.off;
            rem_nxt    = rd_q.len - len_r;
            place_nxt  = rd_q.off;
            reused_nxt = 1'b1;
            sh_nxt     = pos_r;
            rd_addr    = pos_inc[AW-1:0];
            state_nxt  = S_DEL;
          end else begin
            sh_nxt    = total_r;
            rd_addr   = total_dec[AW-1:0];
            state_nxt = S_SHIFT;
          end
        end else if (pos_inc == total_r) begin
          if (scan_alloc_r) begin
            place_nxt = end_r;
            end_nxt   = end_r + OFF_W'(len_r);
            state_nxt = S_DONE;
          end else begin
            // goes at the tail, nothing to move
            pos_nxt   = total_r;
            sh_nxt    = total_r;
            state_nxt = S_SHIFT;
          end
        end else begin
          pos_nxt = pos_inc;
          rd_addr = pos_inc[AW-1:0];
        end
      end
      S_DEL: begin
        if (sh_p1 == total_r) begin
          total_nxt = total_dec;
          if (rem_r > LEN_W'(thr_r)) begin
            ins_off_nxt = hoff_r + OFF_W'(len_r);
            ins_len_nxt = rem_r;
            state_nxt   = S_INSERT;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          // pull the next entry one slot towards the head
          we      = 1'b1;
          wr_addr = sh_r[AW-1:0];
          wr_data = rd_q;
          sh_nxt  = sh_p1;
          rd_addr = sh_p2[AW-1:0];
        end
      end
      S_SHIFT: begin
        if (sh_r == pos_r) begin
          we          = 1'b1;
          wr_addr     = pos_r[AW-1:0];
          wr_data.off = ins_off_r;
          wr_data.len = ins_len_r;
          total_nxt   = total_r + CW'(1);
          if (cmd_r == CMD_ALLOC) split_nxt = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          we      = 1'b1;
          wr_addr = sh_r[AW-1:0];
          wr_data = rd_q;
          sh_nxt  = sh_r - CW'(1);
          rd_addr = sh_m2[AW-1:0];
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_q_nxt.place      = place_r;
          out_q_nxt.reused     = reused_r;
          out_q_nxt.split_done = split_r;
          out_q_nxt.status     = status_r;
          out_q_nxt.hole_count = HC_W'(total_r);
          out_valid_nxt        = 1'b1;
          state_nxt            = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_FIT_MODE:  fit_mode_nxt = cfg_pwdata[MODE_W-1:0];
        REG_SPLIT_THR: thr_nxt      = cfg_pwdata[THR_W-1:0];
        REG_INIT_END: begin
          init_end_nxt = cfg_pwdata[OFF_W-1:0];
          end_nxt      = cfg_pwdata[OFF_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    sh_r         <= sh_nxt;
    cmd_r        <= cmd_nxt;
    len_r        <= len_nxt;
    ins_off_r    <= ins_off_nxt;
    ins_len_r    <= ins_len_nxt;
    hoff_r       <= hoff_nxt;
    rem_r        <= rem_nxt;
    scan_alloc_r <= scan_alloc_nxt;
    place_r      <= place_nxt;
    reused_r     <= reused_nxt;
    split_r      <= split_nxt;
    status_r     <= status_nxt;
    out_q_r      <= out_q_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      end_r       <= INIT_END_RST;
      out_valid_r <= 1'b0;
      fit_mode_r  <= FIT_MODE_RST;
      thr_r       <= SPLIT_THR_RST;
      init_end_r  <= INIT_END_RST;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      end_r       <= end_nxt;
      out_valid_r <= out_valid_nxt;
      fit_mode_r  <= fit_mode_nxt;
      thr_r       <= thr_nxt;
      init_end_r  <= init_end_nxt;
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("transaction accepted while another is in flight");

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= SLOTS)
    else $error("hole total beyond list capacity");

  a_drop_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |-> out_data.hole_count == HC_W'(FREE_SLOTS))
    else $error("hole dropped while the list had room");

  a_split_from_hole: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.split_done |-> out_data.reused && !out_data.status)
    else $error("split reported without a reused hole");

endmodule

[bench/tb_fit_policy_free_block_allocator_core.sv]
`timescale 1ns / 1ps

module tb_fit_policy_free_block_allocator_core;
  import fpa_pkg::*;

  localparam int SLOTS        = 64;
  localparam int PHASE_ITEMS  = 215;
  localparam int HOLD_CYCLES  = 1500;
  localparam int SLOW_CYCLES  = 3 * SLOTS + 8;
  localparam int POOL_DEPTH   = 256;
  // the fourth policy code is not named in the package, it falls back to first-fit
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]   cfg_paddr = '0;
  logic [CFG_DW-1:0]   cfg_pwdata = '0;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  fit_policy_free_block_allocator_core #(
    .FREE_SLOTS(SLOTS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // free list as the block should hold it
  logic [OFF_W-1:0]  fl_base [SLOTS];
  logic [LEN_W-1:0]  fl_size [SLOTS];
  int unsigned       fl_used = 0;
  logic [OFF_W-1:0]  tail_ptr = INIT_END_RST;
  logic [OFF_W-1:0]  tail_init = INIT_END_RST;
  logic [MODE_W-1:0] fit_sel = FIT_MODE_RST;
  logic [THR_W-1:0]  thr_sel = SPLIT_THR_RST;

  out_item_t reply_q [$];
  in_item_t  granted_q [$];
  out_item_t seen;

  int n_err = 0;
  int n_sent = 0;
  int n_results = 0;
  int n_reused = 0;
  int n_split = 0;
  int n_drops = 0;
  int tx_idle = 0;
  int rx_idle = 0;
  int hold_reqs = 0;
  int hold_done = 0;
  int hold_left = 0;

  typedef struct {
    bit               is_cfg;
    logic [1:0]       idx;
    logic [CFG_DW-1:0] val;
    in_item_t         item;
    bit               typed;
    out_item_t        want;
  } step_row_t;

  step_row_t plan_q [$];

  task automatic note(string msg);
    n_err++;
    if (n_err <= 10) begin
      $display("mismatch: %s", msg);
    end
  endtask

  function automatic bit link_hole(logic [OFF_W-1:0] base, logic [LEN_W-1:0] size);
    int unsigned pos;
    int unsigned i;
    pos = 0;
    if (fl_used >= SLOTS) return 1'b0;
    if (fit_sel == MODE_BEST) begin
      while (pos < fl_used && fl_size[pos] <= size) pos++;
    end else if (fit_sel == MODE_WORST) begin
      while (pos < fl_used && fl_size[pos] > size) pos++;
    end
    for (i = fl_used; i > pos; i--) begin
      fl_base[i] = fl_base[i - 1];
      fl_size[i] = fl_size[i - 1];
    end
    fl_base[pos] = base;
    fl_size[pos] = size;
    fl_used++;
    return 1'b1;
  endfunction

  function automatic out_item_t predict_grant(in_item_t it);
    out_item_t        r;
    in_item_t         rec;
    int unsigned      pos;
    int unsigned      i;
    logic [LEN_W-1:0] rest;
    logic [OFF_W-1:0] base;
    r = '0;
    if (it.cmd == CMD_RELEASE) begin
      r.place = it.offset;
      if (!link_hole(it.offset, it.length)) begin
        r.status = 1'b1;
        n_drops++;
      end
    end else begin
      pos = 0;
      while (pos < fl_used && fl_size[pos] < it.length) pos++;
      if (pos < fl_used) begin
        base = fl_base[pos];
        rest = fl_size[pos] - it.length;
        for (i = pos; i + 1 < fl_used; i++) begin
          fl_base[i] = fl_base[i + 1];
          fl_size[i] = fl_size[i + 1];
        end
        fl_used--;
        r.place = base;
        r.reused = 1'b1;
        n_reused++;
        // remainder offset wraps at 31 bits
        if (rest > thr_sel && link_hole(base + it.length, rest)) begin
          r.split_done = 1'b1;
          n_split++;
        end
      end else begin
        r.place = tail_ptr;
        tail_ptr = tail_ptr + it.length;
      end
      if (granted_q.size() < POOL_DEPTH) begin
        rec = {CMD_RELEASE, r.place, it.length};
        granted_q.push_back(rec);
      end
    end
    r.hole_count = HC_W'(fl_used);
    return r;
  endfunction

  // releases mostly give back earlier grants, the rest is arbitrary holes and requests
  function automatic in_item_t random_item(int rel_pct);
    in_item_t it;
    int       idx;
    int       r;
    r = $urandom_range(0, 99);
    it.offset = OFF_W'($urandom);
    if (r < 3) it.length = '0;
    else if (r < 8) it.length = '1;
    else if (r < 20) it.length = LEN_W'($urandom);
    else it.length = LEN_W'($urandom_range(1, 300));
    if ($urandom_range(0, 99) < rel_pct) begin
      it.cmd = CMD_RELEASE;
      if (granted_q.size() != 0 && $urandom_range(0, 9) < 7) begin
        idx = $urandom_range(0, granted_q.size() - 1);
        it = granted_q[idx];
        granted_q.delete(idx);
      end
    end else begin
      it.cmd = CMD_ALLOC;
    end
    return it;
  endfunction

  function automatic void add_row(logic cmd, logic [OFF_W-1:0] off, logic [LEN_W-1:0] len,
                                  bit typed, out_item_t want);
    step_row_t s;
    s = '{default: '0};
    s.item = {cmd, off, len};
    s.typed = typed;
    s.want = want;
    plan_q.push_back(s);
  endfunction

  function automatic void add_cfg(logic [1:0] idx, logic [CFG_DW-1:0] val);
    step_row_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.val = val;
    plan_q.push_back(s);
  endfunction

  task automatic offer(in_item_t it, bit typed, out_item_t want);
    out_item_t got;
    while ($urandom_range(0, 99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    got = predict_grant(it);
    reply_q.push_back(typed ? want : got);
    n_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write one register, then read it back
  task automatic reg_write(logic [1:0] idx, logic [CFG_DW-1:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_FIT_MODE:  fit_sel = val[MODE_W-1:0];
      REG_SPLIT_THR: thr_sel = val[THR_W-1:0];
      REG_INIT_END: begin
        tail_init = val[OFF_W-1:0];
        tail_ptr = val[OFF_W-1:0];
      end
      default: ;
    endcase
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_FIT_MODE: begin
        if (cfg_prdata[MODE_W-1:0] !== fit_sel)
          note($sformatf("fit_mode read exp %0d got %0d", fit_sel, cfg_prdata[MODE_W-1:0]));
      end
      REG_SPLIT_THR: begin
        if (cfg_prdata[THR_W-1:0] !== thr_sel)
          note($sformatf("split_threshold read exp %0d got %0d", thr_sel,
                         cfg_prdata[THR_W-1:0]));
      end
      REG_INIT_END: begin
        if (cfg_prdata[OFF_W-1:0] !== tail_init)
          note($sformatf("initial_end read exp %h got %h", tail_init, cfg_prdata[OFF_W-1:0]));
      end
      default: ;
    endcase
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(logic [MODE_W-1:0] mode, logic [THR_W-1:0] thr,
                           logic [OFF_W-1:0] start, int rel_pct, int tx, int rx,
                           int hold_at, int pause_at);
    int k;
    settle();
    reg_write(REG_FIT_MODE, CFG_DW'(mode));
    reg_write(REG_SPLIT_THR, CFG_DW'(thr));
    reg_write(REG_INIT_END, CFG_DW'(start));
    tx_idle = tx;
    rx_idle = rx;
    for (k = 0; k < PHASE_ITEMS; k++) begin
      if (k == hold_at) hold_reqs++;
      if (k == pause_at) settle();
      offer(random_item(rel_pct), 1'b0, '0);
    end
  endtask

  // receiving side: random back-pressure, plus a long hold when asked
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_reqs != hold_done) begin
      hold_done <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (reply_q.size() == 0) begin
        note($sformatf("transaction %0d with nothing outstanding, place %h", n_results,
                       out_data.place));
      end else begin
        seen = reply_q.pop_front();
        if (out_data.place !== seen.place)
          note($sformatf("#%0d place exp %h got %h", n_results, seen.place, out_data.place));
        if (out_data.reused !== seen.reused)
          note($sformatf("#%0d reused exp %b got %b", n_results, seen.reused,
                         out_data.reused));
        if (out_data.split_done !== seen.split_done)
          note($sformatf("#%0d split_done exp %b got %b", n_results, seen.split_done,
                         out_data.split_done));
        if (out_data.status !== seen.status)
          note($sformatf("#%0d status exp %b got %b", n_results, seen.status,
                         out_data.status));
        if (out_data.hole_count !== seen.hole_count)
          note($sformatf("#%0d hole_count exp %0d got %0d", n_results, seen.hole_count,
                         out_data.hole_count));
      end
      n_results++;
    end
  end

  initial begin : main_seq
    int k;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    tx_idle = 10;
    rx_idle = 58;

    // reset state: first-fit, threshold 10, appends from 4
    add_row(CMD_ALLOC, 31'h7FFF_FFFF, 16'd1, 1'b1, '{31'd4, 1'b0, 1'b0, 1'b0, 7'd0});
    add_row(CMD_ALLOC, 31'd0, 16'hFFFF, 1'b1, '{31'd5, 1'b0, 1'b0, 1'b0, 7'd0});
    add_row(CMD_RELEASE, 31'h7FFF_FFFF, 16'hFFFF, 1'b1,
            '{31'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 7'd1});
    add_row(CMD_RELEASE, 31'd0, 16'd0, 1'b1, '{31'd0, 1'b0, 1'b0, 1'b0, 7'd2});
    // zero request takes the head hole
    add_row(CMD_ALLOC, 31'h2AAA_AAAA, 16'd0, 1'b1, '{31'd0, 1'b1, 1'b0, 1'b0, 7'd1});
    // remainder offset wraps past the top of the range
    add_row(CMD_ALLOC, 31'h5555_5555, 16'd100, 1'b0, '0);
    add_row(CMD_ALLOC, 31'd0, 16'hFFFF, 1'b0, '0);
    // remainder equal to the threshold is wasted
    add_row(CMD_ALLOC, 31'd0, 16'd65425, 1'b0, '0);
    add_cfg(REG_FIT_MODE, CFG_DW'(MODE_BEST));
    add_cfg(REG_SPLIT_THR, 32'd0);
    add_row(CMD_RELEASE, 31'd100, 16'd50, 1'b0, '0);
    add_row(CMD_RELEASE, 31'd200, 16'd50, 1'b0, '0);
    add_row(CMD_RELEASE, 31'd300, 16'd30, 1'b0, '0);
    add_row(CMD_RELEASE, 31'd400, 16'd70, 1'b0, '0);
    add_row(CMD_ALLOC, 31'd0, 16'd40, 1'b0, '0);
    add_row(CMD_ALLOC, 31'd0, 16'd50, 1'b0, '0);
    add_cfg(REG_FIT_MODE, CFG_DW'(MODE_WORST));
    add_cfg(REG_SPLIT_THR, 32'd255);
    add_row(CMD_RELEASE, 31'd500, 16'd70, 1'b0, '0);
    add_row(CMD_RELEASE, 31'd600, 16'd5, 1'b0, '0);
    add_row(CMD_ALLOC, 31'd0, 16'd70, 1'b0, '0);
    add_row(CMD_ALLOC, 31'd0, 16'd1, 1'b0, '0);
    add_cfg(REG_FIT_MODE, CFG_DW'(MODE_SPARE));
    add_cfg(REG_INIT_END, 32'h7FFF_FFFF);
    add_row(CMD_RELEASE, 31'd700, 16'd8, 1'b0, '0);
    add_row(CMD_ALLOC, 31'd0, 16'd1000, 1'b0, '0);
    add_row(CMD_ALLOC, 31'd0, 16'd2, 1'b0, '0);
    add_row(CMD_RELEASE, 31'd800, 16'd3, 1'b0, '0);

    for (k = 0; k < plan_q.size(); k++) begin
      if (plan_q[k].is_cfg) begin
        settle();
        reg_write(plan_q[k].idx, plan_q[k].val);
      end else begin
        offer(plan_q[k].item, plan_q[k].typed, plan_q[k].want);
      end
    end

    run_phase(MODE_FIRST, 8'd0, 31'h7FFF_B000, 70, 10, 58, -1, -1);
    run_phase(MODE_BEST, SPLIT_THR_RST, INIT_END_RST, 45, 10, 58, 80, -1);
    run_phase(MODE_WORST, 8'd255, 31'd0, 70, 58, 10, -1, -1);
    run_phase(MODE_SPARE, 8'd1, OFF_W'($urandom), 45, 58, 10, -1, 100);
    run_phase(MODE_BEST, 8'd3, 31'h7FFF_FFFF, 60, 0, 0, -1, -1);
    run_phase(MODE_WORST, 8'd0, OFF_W'($urandom), 50, 0, 0, -1, -1);

    in_valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (SLOW_CYCLES) @(posedge clk);

    $display("run covered %0d transactions over all four fit policies: %0d reused holes,",
             n_sent, n_reused);
    $display("  %0d remainder splits, %0d releases dropped on a full list, %0d results seen",
             n_split, n_drops, n_results);
    if (n_err == 0 && reply_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
